### hw/rtl/mp2x2_pkg.sv
// Shared types and constants for the 2x2 max pooling block.
// No dependencies; used by max_pool_2x2_with_argmax.
`timescale 1ns / 1ps

package mp2x2_pkg;

   // payload widths
   localparam int SAMPLE_W = 16;
   localparam int INDEX_W  = 26;

   // configuration port
   localparam int CSR_ADDR_W = 2;
   localparam int CSR_DATA_W = 11;
   localparam int DIM_REG_W  = 11;
   localparam int CHAN_REG_W = 7;

   // default maxima for the top-level parameters
   localparam int DEF_MAX_WIDTH    = 1024;
   localparam int DEF_MAX_HEIGHT   = 1024;
   localparam int DEF_MAX_CHANNELS = 64;

   // register values after reset, before clamping
   localparam int RST_WIDTH    = 1024;
   localparam int RST_HEIGHT   = 1024;
   localparam int RST_CHANNELS = 1;

   // pooling window edge
   localparam int POOL = 2;

   // register indexes
   typedef enum logic [CSR_ADDR_W-1:0] {
      REG_IN_WIDTH      = 2'd0,
      REG_IN_HEIGHT     = 2'd1,
      REG_CHANNEL_COUNT = 2'd2
   } csr_reg_type;

endpackage

### hw/rtl/mp2x2_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies; holds the pooling line store.
`timescale 1ns / 1ps

module mp2x2_ram #(
   parameter int DATA_W = 17,
   parameter int DEPTH  = 512,
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [DATA_W-1:0] wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [DATA_W-1:0] rd_data
);

   logic [DATA_W-1:0] mem_ff [DEPTH];
   logic [DATA_W-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // registered read port
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### hw/rtl/max_pool_2x2_with_argmax.sv
// 2x2 stride-2 max pooling with winner index, top level.
// Depends on mp2x2_pkg and mp2x2_ram.
`timescale 1ns / 1ps

// Samples enter in raster order (channel, row, column), one per cycle at full
// rate, and each 2x2 window yields its largest value and the flat input index
// of that sample, ties going to the earliest sample in scan order. A result
// is registered in the output register after the window's bottom-right
// sample leaves the input stage; the block keeps accepting samples while a
// result waits, and stalls input only when a new result finds the output
// register still full. The top row's pair winners live in a line store of
// MAX_WIDTH/2 entries (one read and one write port), which needs no clearing
// since every entry is written on the top row before the bottom row reads it.
// An odd last row or column is consumed without a result. A write to any of
// the three registers restarts the map at channel 0, row 0, column 0; values
// of 0 act as 1 and values above a maximum act as that maximum. The index
// counts samples from the map start and is kept to its low 26 bits.
module max_pool_2x2_with_argmax #(
   parameter int MAX_WIDTH    = mp2x2_pkg::DEF_MAX_WIDTH,
   parameter int MAX_HEIGHT   = mp2x2_pkg::DEF_MAX_HEIGHT,
   parameter int MAX_CHANNELS = mp2x2_pkg::DEF_MAX_CHANNELS
) (
   input  logic                                clock,
   input  logic                                reset,
   // request channel
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [15:0]                         req_tdata,  // [15:0] sample
   // result channel
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [47:0]                         rsp_tdata,  // [15:0] max_value,
                                                           // [41:16] max_index
   output logic                                rsp_tlast,  // last_window
   // configuration port
   input  logic                                csr_we,
   input  logic [mp2x2_pkg::CSR_ADDR_W-1:0]    csr_addr,
   input  logic [mp2x2_pkg::CSR_DATA_W-1:0]    csr_wdata
);

   localparam int SW  = mp2x2_pkg::SAMPLE_W;
   localparam int IW  = mp2x2_pkg::INDEX_W;
   localparam int WW  = $clog2(MAX_WIDTH + 1);
   localparam int HW  = $clog2(MAX_HEIGHT + 1);
   localparam int CCW = $clog2(MAX_CHANNELS + 1);
   localparam int CW  = $clog2(MAX_WIDTH);
   localparam int RW  = $clog2(MAX_HEIGHT);
   localparam int CHW = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
   localparam int LINE_DEPTH = MAX_WIDTH / mp2x2_pkg::POOL;
   localparam int AW  = (LINE_DEPTH > 1) ? $clog2(LINE_DEPTH) : 1;
   localparam int RST_W = (mp2x2_pkg::RST_WIDTH > MAX_WIDTH) ? MAX_WIDTH
                                                             : mp2x2_pkg::RST_WIDTH;
   localparam int RST_H = (mp2x2_pkg::RST_HEIGHT > MAX_HEIGHT) ? MAX_HEIGHT
                                                               : mp2x2_pkg::RST_HEIGHT;
   localparam int RST_C = (mp2x2_pkg::RST_CHANNELS > MAX_CHANNELS) ? MAX_CHANNELS
                                                                   : mp2x2_pkg::RST_CHANNELS;

   // clamped configuration
   logic [WW-1:0]  width_ff, width_in;
   logic [HW-1:0]  height_ff, height_in;
   logic [CCW-1:0] chans_ff, chans_in;

   // stream position of the next request
   logic [CW-1:0]  col_ff, col_in;
   logic [RW-1:0]  row_ff, row_in;
   logic [CHW-1:0] chan_ff, chan_in;
   logic [IW-1:0]  flat_ff, flat_in;
   logic [SW-1:0]  left_hold_ff, left_hold_in;

   // input stage
   logic           s1_valid_ff, s1_valid_in;
   logic [SW-1:0]  s1_sample_ff;
   logic [SW-1:0]  s1_left_ff;
   logic           s1_col_odd_ff;
   logic           s1_row_odd_ff;
   logic           s1_last_ff;
   logic [IW-1:0]  s1_flat_ff;
   logic [AW-1:0]  s1_slot_ff;

   // result register
   logic           rsp_valid_ff, rsp_valid_in;
   logic [SW-1:0]  rsp_value_ff;
   logic [IW-1:0]  rsp_index_ff;
   logic           rsp_last_ff;

   logic           req_accept;
   logic           cfg_hit;
   logic           s1_produce;
   logic           s1_advance;
   logic [WW-1:0]  col_next;
   logic [HW-1:0]  row_next;
   logic [CCW-1:0] chan_next;
   logic           last_window;
   logic [AW-1:0]  req_slot;

   logic           right_wins;
   logic [SW-1:0]  pair_value;
   logic           bottom_wins;
   logic [SW-1:0]  top_value;
   logic           top_col;
   logic [IW-1:0]  top_index;
   logic [IW-1:0]  bot_index;
   logic           ram_we;
   logic [SW:0]    ram_rd_data;

   // handshake
   assign s1_produce = s1_row_odd_ff & s1_col_odd_ff;
   assign s1_advance = s1_valid_ff & (~s1_produce | ~rsp_valid_ff | rsp_tready);
   assign req_tready = ~s1_valid_ff | s1_advance;
   assign req_accept = req_tvalid & req_tready;

   // configuration decode with clamping
   always_comb begin
      width_in  = width_ff;
      height_in = height_ff;
      chans_in  = chans_ff;
      cfg_hit   = 1'b0;
      if (csr_we) begin
         case (mp2x2_pkg::csr_reg_type'(csr_addr))
            mp2x2_pkg::REG_IN_WIDTH: begin
               cfg_hit = 1'b1;
               if (csr_wdata[mp2x2_pkg::DIM_REG_W-1:0] == '0)
                  width_in = WW'(1);
               else if (int'(csr_wdata[mp2x2_pkg::DIM_REG_W-1:0]) > MAX_WIDTH)
                  width_in = WW'(MAX_WIDTH);
               else
                  width_in = WW'(csr_wdata[mp2x2_pkg::DIM_REG_W-1:0]);
            end
            mp2x2_pkg::REG_IN_HEIGHT: begin
               cfg_hit = 1'b1;
               if (csr_wdata[mp2x2_pkg::DIM_REG_W-1:0] == '0)
                  height_in = HW'(1);
               else if (int'(csr_wdata[mp2x2_pkg::DIM_REG_W-1:0]) > MAX_HEIGHT)
                  height_in = HW'(MAX_HEIGHT);
               else
                  height_in = HW'(csr_wdata[mp2x2_pkg::DIM_REG_W-1:0]);
            end
            mp2x2_pkg::REG_CHANNEL_COUNT: begin
               cfg_hit = 1'b1;
               if (csr_wdata[mp2x2_pkg::CHAN_REG_W-1:0] == '0)
                  chans_in = CCW'(1);
               else if (int'(csr_wdata[mp2x2_pkg::CHAN_REG_W-1:0]) > MAX_CHANNELS)
                  chans_in = CCW'(MAX_CHANNELS);
               else
                  chans_in = CCW'(csr_wdata[mp2x2_pkg::CHAN_REG_W-1:0]);
            end
            default: cfg_hit = 1'b0;
         endcase
      end
   end

   // position counters and left-sample hold
   assign col_next  = WW'(col_ff) + WW'(1);
   assign row_next  = HW'(row_ff) + HW'(1);
   assign chan_next = CCW'(chan_ff) + CCW'(1);
   assign req_slot  = AW'(col_ff >> 1);
   assign last_window = (chan_next == chans_ff)
                        && (row_next >= {height_ff[HW-1:1], 1'b0})
                        && (col_next >= {width_ff[WW-1:1], 1'b0});

   always_comb begin
      col_in       = col_ff;
      row_in       = row_ff;
      chan_in      = chan_ff;
      flat_in      = flat_ff;
      left_hold_in = left_hold_ff;
      if (cfg_hit) begin
         col_in  = '0;
         row_in  = '0;
         chan_in = '0;
         flat_in = '0;
      end else if (req_accept) begin
         if (~col_ff[0]) left_hold_in = req_tdata;
         flat_in = flat_ff + IW'(1);
         col_in  = CW'(col_next);
         if (col_next >= width_ff) begin
            col_in = '0;
            row_in = RW'(row_next);
            if (row_next >= height_ff) begin
               row_in  = '0;
               chan_in = CHW'(chan_next);
               if (chan_next >= chans_ff) begin
                  chan_in = '0;
               end
            end
            if ((row_next >= height_ff) && (chan_next >= chans_ff)) begin
               flat_in = '0;
            end
         end
      end
   end

   // input stage and result valid control
   assign s1_valid_in = req_accept ? 1'b1 : (s1_advance ? 1'b0 : s1_valid_ff);

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (s1_advance && s1_produce) rsp_valid_in = 1'b1;
      else if (rsp_tready)          rsp_valid_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff     <= WW'(RST_W);
         height_ff    <= HW'(RST_H);
         chans_ff     <= CCW'(RST_C);
         col_ff       <= '0;
         row_ff       <= '0;
         chan_ff      <= '0;
         flat_ff      <= '0;
         left_hold_ff <= '0;
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         width_ff     <= width_in;
         height_ff    <= height_in;
         chans_ff     <= chans_in;
         col_ff       <= col_in;
         row_ff       <= row_in;
         chan_ff      <= chan_in;
         flat_ff      <= flat_in;
         left_hold_ff <= left_hold_in;
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // input stage payload
   always_ff @(posedge clock) begin
      if (req_accept) begin
         s1_sample_ff  <= req_tdata;
         s1_left_ff    <= left_hold_ff;
         s1_col_odd_ff <= col_ff[0];
         s1_row_odd_ff <= row_ff[0];
         s1_last_ff    <= last_window;
         s1_flat_ff    <= flat_ff;
         s1_slot_ff    <= req_slot;
      end
   end

   // line store of top-row pair winners: {column bit, value}
   assign ram_we = s1_advance & s1_col_odd_ff & ~s1_row_odd_ff;

   mp2x2_ram #(
      .DATA_W (SW + 1),
      .DEPTH  (LINE_DEPTH)
   ) u_line_store (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (s1_slot_ff),
      .wr_data ({right_wins, pair_value}),
      .rd_en   (req_accept),
      .rd_addr (req_slot),
      .rd_data (ram_rd_data)
   );

   // pair and window compare, earlier sample kept on ties
   assign right_wins  = $signed(s1_sample_ff) > $signed(s1_left_ff);
   assign pair_value  = right_wins ? s1_sample_ff : s1_left_ff;
   assign top_value   = ram_rd_data[SW-1:0];
   assign top_col     = ram_rd_data[SW];
   assign bottom_wins = $signed(pair_value) > $signed(top_value);
   assign top_index   = s1_flat_ff - IW'(width_ff) - IW'(1) + IW'(top_col);
   assign bot_index   = s1_flat_ff - IW'(1) + IW'(right_wins);

   // result register
   always_ff @(posedge clock) begin
      if (s1_advance && s1_produce) begin
         rsp_value_ff <= bottom_wins ? pair_value : top_value;
         rsp_index_ff <= bottom_wins ? bot_index : top_index;
         rsp_last_ff  <= s1_last_ff;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {6'b0, rsp_index_ff, rsp_value_ff};
   assign rsp_tlast  = rsp_last_ff;

   // a new result only comes from a bottom-right sample
   a_result_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(s1_valid_ff && s1_row_odd_ff && s1_col_odd_ff))
      else $error("result raised without a bottom-right sample");

   // request stall only while the input stage is occupied and the result is blocked
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      !req_tready |-> (s1_valid_ff && rsp_valid_ff && !rsp_tready))
      else $error("request stalled without a blocked result");

   // column position stays inside the configured width
   a_col_range: assert property (@(posedge clock) disable iff (reset)
      WW'(col_ff) < width_ff)
      else $error("column counter out of range");

   // flat index restarts together with the position
   a_flat_origin: assert property (@(posedge clock) disable iff (reset)
      (col_ff == '0 && row_ff == '0 && chan_ff == '0) |-> flat_ff == '0)
      else $error("flat index not zero at map start");

   // line store is written only by a top-row right sample leaving the stage
   a_store_write: assert property (@(posedge clock) disable iff (reset)
      ram_we |-> (s1_valid_ff && !s1_produce))
      else $error("line store written by a bottom-row sample");

endmodule
